/* design/rlpg_pkg.sv */
package rlpg_pkg;

  localparam int COLOR_W   = 24;
  localparam int INDEX_W   = 6;
  localparam int CHAN_W    = 8;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_CFG_W = 7;
  localparam int ROT_W     = 10;

  // Wheel spans 767 positions; rotation itself runs 0..767.
  localparam logic [ROT_W-1:0] WHEEL_LAST = 10'd766;
  localparam logic [ROT_W-1:0] ROT_MAX    = 10'd767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_MODE   = 2'd0,
    REG_INTENSITY    = 2'd1,
    REG_STATIC_COLOR = 2'd2,
    REG_PIXEL_COUNT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic frame;   // tick word taken this cycle
    logic issue;   // push the current pixel into the pipe
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;   // frame length is zero
    logic last;    // current pixel is the final one
    logic adv;     // pipe moves this cycle
  } dp_sts_t;

  // floor(x / 255) for x up to 255*255, no divider needed
  function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

/* design/rlpg_ctrl.sv */
module rlpg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_frame_tick,
  output logic               in_stall,
  input  rlpg_pkg::dp_sts_t  sts,
  output rlpg_pkg::ctrl_cmd_t cmd
);
  import rlpg_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cmd.frame = accept && in_frame_tick;
  assign cmd.issue = (state_r == ST_RUN);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.frame && !sts.empty) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.adv && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* design/rlpg_datapath.sv */
module rlpg_datapath #(
  parameter int MAX_PIXELS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rlpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlpg_pkg::CFG_W-1:0]    cfg_wdata,
  input  rlpg_pkg::ctrl_cmd_t           cmd,
  output rlpg_pkg::dp_sts_t             sts,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [rlpg_pkg::INDEX_W-1:0]  out_pixel_index,
  output logic [rlpg_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic                          out_last_pixel
);
  import rlpg_pkg::*;

  localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W = ($clog2(MAX_PIXELS + 1) > CNT_CFG_W) ?
                         $clog2(MAX_PIXELS + 1) : CNT_CFG_W;

  // config registers
  logic                 light_mode_r;
  logic [CHAN_W-1:0]    intensity_r;
  logic [COLOR_W-1:0]   static_color_r;
  logic [CNT_CFG_W-1:0] pixel_count_r;

  // issue stage
  logic [ROT_W-1:0] rot_r, rot_nxt;
  logic [ROT_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // multiply stage
  logic                s1_valid_r;
  logic [INDEX_W-1:0]  s1_idx_r;
  logic                s1_last_r;
  logic                s1_hi_r;
  logic                s1_mid_r;
  logic [15:0]         s1_pg_r;
  logic [15:0]         s1_ph_r;

  logic                out_valid_r;
  logic [INDEX_W-1:0]  out_idx_r;
  logic [COLOR_W-1:0]  out_color_r;
  logic                out_last_r;

  logic [CNT_W-1:0]       cnt_ext, n_pix;
  logic [IDX_W+INDEX_W-1:0] idx_wide;
  logic [CHAN_W-1:0]      p, p_inv, g, h;
  logic [COLOR_W-1:0]     color;
  logic                   en, push;

  assign en   = !out_valid_r || !out_stall;
  assign push = cmd.issue && en;

  assign cnt_ext = CNT_W'(pixel_count_r);
  assign n_pix   = (cnt_ext > CNT_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS) : cnt_ext;

  assign sts.empty = (n_pix == '0);
  assign sts.last  = (CNT_W'(idx_r) == n_pix - CNT_W'(1));
  assign sts.adv   = en;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_mode_r   <= 1'b0;
      intensity_r    <= 8'hFF;
      static_color_r <= 24'hFFFFFF;
      pixel_count_r  <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LIGHT_MODE:   light_mode_r   <= cfg_wdata[0];
        REG_INTENSITY:    intensity_r    <= cfg_wdata[CHAN_W-1:0];
        REG_STATIC_COLOR: static_color_r <= cfg_wdata[COLOR_W-1:0];
        REG_PIXEL_COUNT:  pixel_count_r  <= cfg_wdata[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // rotation, wheel position, pixel counter
  always_comb begin
    rot_nxt = rot_r;
    pos_nxt = pos_r;
    idx_nxt = idx_r;
    if (cmd.frame) begin
      if (!light_mode_r) rot_nxt = (rot_r == ROT_MAX) ? '0 : rot_r + ROT_W'(1);
      pos_nxt = (rot_r == ROT_MAX) ? '0 : rot_r;
      idx_nxt = '0;
    end else if (push) begin
      pos_nxt = (pos_r == WHEEL_LAST) ? '0 : pos_r + ROT_W'(1);
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r <= '0;
      pos_r <= '0;
      idx_r <= '0;
    end else begin
      rot_r <= rot_nxt;
      pos_r <= pos_nxt;
      idx_r <= idx_nxt;
    end
  end

  // stage 1: two 8x8 products
  assign p        = pos_r[CHAN_W-1:0];
  assign p_inv    = 8'hFF - p;
  assign idx_wide = (IDX_W+INDEX_W)'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (en) s1_valid_r <= cmd.issue;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx_r  <= idx_wide[INDEX_W-1:0];
      s1_last_r <= sts.last;
      s1_hi_r   <= pos_r[9];
      s1_mid_r  <= pos_r[8];
      s1_pg_r   <= 16'(p) * 16'(intensity_r);
      s1_ph_r   <= 16'(p_inv) * 16'(intensity_r);
    end
  end

  // stage 2: scale and place on the wheel
  assign g = div255(s1_pg_r);
  assign h = div255(s1_ph_r);

  always_comb begin
    if (light_mode_r)  color = static_color_r;
    else if (s1_hi_r)  color = {h, 8'h00, g};
    else if (s1_mid_r) color = {g, h, 8'h00};
    else               color = {8'h00, g, h};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_idx_r   <= s1_idx_r;
      out_color_r <= color;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_idx_r;
  assign out_pixel_color = out_color_r;
  assign out_last_pixel  = out_last_r;

endmodule

/* design/rainbow_led_pattern_generator.sv */
// Rainbow LED pattern generator. Each frame_tick word produces one color
// word per pixel, pixel 0 first, with last_pixel set on the final one; a
// word with frame_tick low produces nothing. pixel_count (saturated at
// MAX_PIXELS) sets the frame length, and a count of zero gives no words.
// Rainbow mode walks the 767-step color wheel starting at the current
// rotation and advances the rotation by one per frame; static mode sends
// static_color everywhere and leaves the rotation alone. After the tick is
// taken, pixels enter a two-stage pipe (multiply, then scale and place) one
// per cycle while out_stall does not hold the output register. in_stall
// drops again once the last pixel has entered the pipe. The user must write
// config registers only while the block is quiet; the block itself does not
// enforce this.
module rainbow_led_pattern_generator #(
  parameter int MAX_PIXELS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // tick channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_frame_tick,
  // pixel channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rlpg_pkg::INDEX_W-1:0]  out_pixel_index,
  output logic [rlpg_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic                          out_last_pixel,
  // register writes
  input  logic                          cfg_we,
  input  logic [rlpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlpg_pkg::CFG_W-1:0]    cfg_wdata
);
  import rlpg_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer: idle / running a frame
  rlpg_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_frame_tick (in_frame_tick),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  // registers, wheel position, color pipe
  rlpg_datapath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

/* design/rlpg_checker.sv */
module rlpg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rlpg_pkg::INDEX_W-1:0]  out_pixel_index,
  input logic [rlpg_pkg::COLOR_W-1:0]  out_pixel_color,
  input logic                          out_last_pixel
);

  // held word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_index)
      && $stable(out_pixel_color) && $stable(out_last_pixel))
    else $error("pixel word changed while stalled");

  // reset leaves block ready and output empty
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // a frame never breaks between pixels
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_pixel |=> out_valid)
    else $error("gap inside frame");

  // indexes climb by one inside a frame
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_pixel
      |=> out_pixel_index == $past(out_pixel_index) + 6'd1)
    else $error("pixel index skipped");

endmodule

bind rainbow_led_pattern_generator rlpg_checker u_chk (.*);
